// ===== hdl/srtfc_pkg.sv =====
// Package: widths, request codes, status codes, flag bits, entry and cell interface types and sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package srtfc_pkg;
	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_W = 32 - PAGE_SHIFT;
	localparam int END_W = PAGE_W + 1;
	localparam int SLOT_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	localparam logic [1:0] REQ_MAP = 2'd0;
	localparam logic [1:0] REQ_FAULT = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int FL_READ = 0;
	localparam int FL_WRITE = 1;
	localparam int FL_EXEC = 2;
	localparam int FL_STACK = 3;

	typedef struct packed {
		logic [PAGE_W-1:0] start_pg;
		logic [END_W-1:0] end_pg;
		logic [3:0] flags;
	} entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic ins;              // insert at ins_pos, shift upward
		logic [SLOT_W-1:0] ins_pos;
		entry_t ins_entry;
	} cell_cmd_t;

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_OUT} state_t;
endpackage
`default_nettype wire

// ===== hdl/srtfc_cell.sv =====
// One table cell: holds an entry, shifts from its lower neighbor on insert.
`timescale 1ns / 1ps
`default_nettype none
module srtfc_cell
	import srtfc_pkg::*;
(
	input wire logic clk,
	input wire logic [SLOT_W-1:0] idx,
	input wire cell_cmd_t cmd,
	input wire entry_t prev_entry,
	output entry_t entry
);
	entry_t entry_q;
	assign entry = entry_q;

	// Take the new entry at the insert point, the neighbor's above it.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx == cmd.ins_pos) entry_q <= cmd.ins_entry;
			else if (idx > cmd.ins_pos) entry_q <= prev_entry;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sorted_region_table_fault_check.sv =====
// Top level: request handshake, lookup/insert control and the cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Sorted region table with fault check. The request type travels on s_tuser;
// address, length, flags and fault code travel on s_tdata. A request is
// accepted only while the sequencer is idle. In the cycle after acceptance
// every cell compares its entry in parallel, the first hit and the insert
// point are found, and on the edge that ends that cycle an insert shifts the
// chain of cells and the result is registered. In the output state the
// result moves into the output register once the receiver has taken the
// previous result, and the sequencer then returns to idle to accept the next
// request; it takes no new request before it is through with the last one.
// A stalled receiver holds the sequencer in its output state.
// A new request is taken while a result waits in the output register.
// Table entries hold no reset value; only entries below the region count
// are ever read. Config writes go to user_base (index 0) and user_top
// (index 1).
module sorted_region_table_fault_check
	import srtfc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// addr[31:0], length[63:32], region_flags[67:64], fault_code[69:68]
	input wire logic [71:0] s_tdata,
	// req_type[1:0]
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// status[1:0], slot[5:2], region_start[37:6], region_end[69:38],
	// page_addr[101:70], write_perm[102]
	output logic [103:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	logic [31:0] user_base_q, user_top_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_base_q <= 32'h0020_0000;
			user_top_q <= 32'hB000_0000;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) user_base_q <= cfg_data;
			else user_top_q <= cfg_data;
		end
	end

	state_t state_q, state_d;
	logic [71:0] req_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] lh_slot_q;
	logic lh_valid_q;
	logic out_valid_q;
	logic [103:0] out_q;

	logic [1:0] r_type;
	logic [31:0] r_addr, r_len;
	logic [3:0] r_flags;
	logic [1:0] r_code;
	assign r_type = req_q[1:0];
	assign r_addr = req_q[33:2];
	assign r_len = req_q[65:34];
	assign r_flags = req_q[69:66];
	assign r_code = req_q[71:70];

	// Cell chain
	entry_t ent [MAX_REGIONS];
	cell_cmd_t cmd;
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		entry_t prev;
		if (g == 0) begin : g_first
			assign prev = ent[0];
		end else begin : g_rest
			assign prev = ent[g-1];
		end
		srtfc_cell u_cell (
			.clk(clk),
			.idx(SLOT_W'(g)),
			.cmd(cmd),
			.prev_entry(prev),
			.entry(ent[g])
		);
	end

	// Map range rounding
	logic [32:0] m_sum, m_e;
	logic [PAGE_W-1:0] m_sp;
	logic [END_W-1:0] m_ep;
	logic [32:0] m_s;
	logic map_ok;
	assign m_sum = {1'b0, r_addr} + {1'b0, r_len} + 33'(PAGE_BYTES - 1);
	assign m_sp = r_addr[31:PAGE_SHIFT];
	assign m_ep = m_sum[32:PAGE_SHIFT];
	assign m_s = {1'b0, m_sp, {PAGE_SHIFT{1'b0}}};
	assign m_e = {m_ep, {PAGE_SHIFT{1'b0}}};
	assign map_ok = (m_s >= {1'b0, user_base_q}) && (m_s < m_e)
		&& (m_e <= {1'b0, user_top_q});

	// Lookup key in pages: map uses the start page, fault the address page
	logic [PAGE_W-1:0] key_pg;
	assign key_pg = (r_type == REQ_MAP) ? m_sp : r_addr[31:PAGE_SHIFT];

	// Per-cell compares and first-hit search
	logic [MAX_REGIONS-1:0] live, endabove, startle;
	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			live[i] = CNT_W'(i) < count_q;
			endabove[i] = live[i] && (ent[i].end_pg > {1'b0, key_pg});
			startle[i] = live[i] && (ent[i].start_pg <= m_sp);
		end
	end

	logic found;
	logic [SLOT_W-1:0] first_hit;
	logic [SLOT_W-1:0] ins_pos;
	always_comb begin
		found = 1'b0;
		first_hit = '0;
		for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
			if (endabove[i]) begin
				found = 1'b1;
				first_hit = SLOT_W'(i);
			end
		end
		ins_pos = SLOT_W'(count_q);
		for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
			if (live[i] && !startle[i]) ins_pos = SLOT_W'(i);
		end
	end

	// Last-hit cache check
	logic lh_use;
	entry_t lh_e;
	assign lh_e = ent[lh_slot_q];
	assign lh_use = lh_valid_q && (CNT_W'(lh_slot_q) < count_q)
		&& (lh_e.start_pg <= key_pg) && (lh_e.end_pg > {1'b0, key_pg});

	logic hit;
	logic [SLOT_W-1:0] hslot;
	entry_t he;
	assign hit = lh_use || found;
	assign hslot = lh_use ? lh_slot_q : first_hit;
	assign he = ent[hslot];

	// Evaluate request
	logic [1:0] st;
	logic [SLOT_W-1:0] o_slot;
	logic [31:0] o_rs, o_re, o_pa;
	logic o_wp;
	logic do_ins, upd_lh, clr;
	logic ok;
	logic [32:0] hs, he_a, a33;
	assign hs = {1'b0, he.start_pg, {PAGE_SHIFT{1'b0}}};
	assign he_a = {he.end_pg, {PAGE_SHIFT{1'b0}}};
	assign a33 = {1'b0, r_addr};
	always_comb begin
		st = ST_BAD; o_slot = '0; o_rs = '0; o_re = '0; o_pa = '0; o_wp = 1'b0;
		do_ins = 1'b0; upd_lh = 1'b0; clr = 1'b0; ok = 1'b0;
		unique case (r_type)
			REQ_MAP: begin
				if (map_ok) begin
					upd_lh = !lh_use && found;
					if (hit && (m_e > hs)) st = ST_BAD;
					else if (count_q == CNT_W'(MAX_REGIONS)) st = ST_FULL;
					else begin
						st = ST_OK; do_ins = 1'b1; o_slot = ins_pos;
						o_rs = m_s[31:0]; o_re = m_e[31:0];
					end
				end
			end
			REQ_FAULT: begin
				upd_lh = !lh_use && found;
				if (hit && !(hs > a33)
					&& !(he.flags[FL_STACK] && a33 < hs + 33'(PAGE_BYTES))) begin
					if (r_code[1]) ok = he.flags[FL_WRITE];
					else if (r_code[0]) ok = 1'b0;
					else ok = he.flags[FL_READ] || he.flags[FL_EXEC];
					if (ok) begin
						st = ST_OK; o_slot = hslot; o_rs = hs[31:0]; o_re = he_a[31:0];
						o_pa = {r_addr[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
						o_wp = he.flags[FL_WRITE];
					end
				end
			end
			REQ_CLEAR: begin
				st = ST_OK; clr = 1'b1;
			end
			default: st = ST_BAD;
		endcase
	end

	logic eval;
	assign eval = (state_q == S_EVAL);
	assign cmd.ins = eval && do_ins;
	assign cmd.ins_pos = ins_pos;
	assign cmd.ins_entry = '{start_pg: m_sp, end_pg: m_ep, flags: r_flags};

	// Sequencer
	assign s_tready = (state_q == S_IDLE);
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_EVAL;
			S_EVAL: state_d = S_OUT;
			S_OUT: if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [103:0] res_q;
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) req_q <= {s_tdata[69:0], s_tuser};
		if (eval) res_q <= {1'b0, o_wp, o_pa, o_re, o_rs, o_slot, st};
		if (state_q == S_OUT && (!out_valid_q || m_tready)) out_q <= res_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lh_slot_q <= '0;
			lh_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (eval) begin
				if (clr) begin
					count_q <= '0; lh_valid_q <= 1'b0; lh_slot_q <= '0;
				end else begin
					if (upd_lh) begin
						lh_valid_q <= 1'b1;
						lh_slot_q <= (do_ins && first_hit >= ins_pos)
							? first_hit + 1'b1 : first_hit;
					end else if (do_ins && lh_valid_q && lh_slot_q >= ins_pos)
						lh_slot_q <= lh_slot_q + 1'b1;
					if (do_ins) count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
endmodule
`default_nettype wire
